// ===== hw/rtl/kalman_angle_bias_filter_assert.svh =====
// Assertion macros used by the port checker of the tilt filter.
`ifndef KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define KAB_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("kab: property failed");

// A held condition keeps a signal stable into the next cycle.
`define KAB_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
	else $error("kab: signal changed while held");

`endif

// ===== hw/rtl/kab_pkg.sv =====
// Types, constants and helpers for the angle/bias Kalman filter.
`timescale 1ns / 1ps
package kab_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DT_BITS   = 16;
	localparam int ST_W      = 32;
	localparam int IN_W      = 25;
	localparam int DT_W      = 16;
	localparam int NOISE_W   = 16;
	localparam int MEAS_N_W  = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int WIDE_W    = 64;

	// shift-add multiplier, 4-bit digits
	localparam int MUL_W     = 36;
	localparam int DIG_W     = 4;
	localparam int MUL_STEPS = MUL_W / DIG_W;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int MCNT_W    = $clog2(MUL_STEPS);

	// restoring divider, one quotient bit per cycle
	localparam int DEN_W  = 33;
	localparam int DVD_W  = ST_W + FRAC_BITS;
	localparam int DCNT_W = $clog2(DVD_W);

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd2;

	localparam logic [NOISE_W-1:0]  ANGLE_NOISE_RST   = 16'd66;
	localparam logic [NOISE_W-1:0]  BIAS_NOISE_RST    = 16'd197;
	localparam logic [MEAS_N_W-1:0] MEASURE_NOISE_RST = 24'd81920;

	localparam logic signed [ST_W-1:0] ONE_Q = ST_W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [IN_W-1:0] ANGLE_LIMIT = 25'sd11796480;

	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [ST_W-1:0]   st_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		OP_ANG, OP_D11, OP_INN, OP_BN, OP_K0, OP_K1,
		OP_KA, OP_KB, OP_PBA, OP_PAA, OP_PBB, OP_PAB
	} op_t;

	function automatic st_t sat32(input wide_t v);
		if (v > wide_t'(64'sd2147483647))
			return st_t'(32'sh7fffffff);
		else if (v < -wide_t'(64'sd2147483648))
			return st_t'(32'sh80000000);
		else
			return st_t'(v);
	endfunction

endpackage

// ===== hw/rtl/kab_mul.sv =====
// Signed digit-serial multiplier, 4 multiplier bits per cycle, LSB first.
`timescale 1ns / 1ps
module kab_mul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [kab_pkg::MUL_W-1:0]   a,
	input  logic signed [kab_pkg::MUL_W-1:0]   b,
	output logic                               done,
	output logic signed [kab_pkg::PROD_W-1:0]  prod
);
	import kab_pkg::*;

	logic signed [MUL_W-1:0]       a_q;
	logic signed [MUL_W+5:0]       hi_q;
	logic [MUL_W-1:0]              lo_q;
	logic [MCNT_W-1:0]             cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic                          last;
	logic signed [DIG_W:0]         dig;
	logic signed [MUL_W+DIG_W:0]   pp;
	logic signed [MUL_W+5:0]       sum;

	assign last = (cnt_q == MCNT_W'(MUL_STEPS - 1));
	// top digit carries the sign of b
	assign dig  = last ? {lo_q[DIG_W-1], lo_q[DIG_W-1:0]} : {1'b0, lo_q[DIG_W-1:0]};
	assign pp   = a_q * dig;
	assign sum  = hi_q + (MUL_W+6)'(pp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum >>> DIG_W;
			lo_q <= {sum[DIG_W-1:0], lo_q[MUL_W-1:DIG_W]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q[MUL_W-1:0], lo_q};

endmodule

// ===== hw/rtl/kab_div.sv =====
// Restoring divider for the Kalman gain: sat32(trunc(num * 2^FRAC / den)).
`timescale 1ns / 1ps
module kab_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [kab_pkg::ST_W-1:0]  num,
	input  logic [kab_pkg::DEN_W-1:0]        den,
	output logic                             done,
	output logic signed [kab_pkg::ST_W-1:0]  quo
);
	import kab_pkg::*;

	logic [DEN_W-1:0]   rem_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [DEN_W-1:0]   den_q;
	logic               neg_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [ST_W-1:0]    mag;
	logic [DEN_W:0]     trial;
	logic [DEN_W:0]     diff;
	logic               ge;
	logic signed [DVD_W:0] qs;

	assign mag   = num[ST_W-1] ? (~num + 1'b1) : num;
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= {mag, {FRAC_BITS{1'b0}}};
			den_q <= den;
			neg_q <= num[ST_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	// quotient replaced the dividend bit by bit; apply sign, then clamp
	assign qs   = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
	assign quo  = sat32(wide_t'(qs));
	assign done = done_q;

endmodule

// ===== hw/rtl/kalman_angle_bias_filter.sv =====
// Top level: two-state angle/gyro-bias Kalman filter for one tilt axis.
// Usage:
//   Input channel (in_valid/in_ready) takes one beat of measured_angle,
//   measured_rate and time_step; output channel (out_valid/out_ready)
//   returns one beat of filtered_angle per input beat, in order.
//   Config: cfg_we writes cfg_data to register cfg_index (0 angle_noise,
//   1 bias_noise, 2 measure_noise); other indexes are ignored. Write only
//   while idle.
//   Processing: the measurement correction runs only when the innovation
//   variance is positive. The block works on one beat at a time; in_ready
//   rises with out_valid, so a new beat is not taken before the result of
//   the last one is issued.
//   The cost is set by one shared 4-bit-digit multiplier (up to ten
//   products) and a radix-2 divider (two gains).
//   Reset: angle and bias zero, covariance identity, registers default.
//   A stalled receiver holds the result register; the next result waits
//   in its final step and in_ready stays low until the register frees.
`timescale 1ns / 1ps
module kalman_angle_bias_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [kab_pkg::IN_W-1:0]      measured_angle,
	input  logic signed [kab_pkg::IN_W-1:0]      measured_rate,
	input  logic [kab_pkg::DT_W-1:0]             time_step,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [kab_pkg::IN_W-1:0]      filtered_angle,
	input  logic                                 cfg_we,
	input  logic [kab_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [kab_pkg::CFG_W-1:0]            cfg_data
);
	import kab_pkg::*;

	state_t state_q;
	op_t    op_q;

	logic [NOISE_W-1:0]  angle_noise_q;
	logic [NOISE_W-1:0]  bias_noise_q;
	logic [MEAS_N_W-1:0] measure_noise_q;

	st_t ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q;
	st_t d11_q, k0_q, k1_q, y_q;
	logic [DEN_W-1:0] s_q;

	logic signed [IN_W-1:0] meas_q;
	logic signed [IN_W-1:0] rin_q;
	logic [DT_W-1:0]        dt_q;

	logic signed [IN_W-1:0] out_q;
	logic                   out_valid_q;

	logic mstart_q, dstart_q;
	logic mul_done, div_done;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_prod;
	st_t  div_num, div_quo;

	wide_t pdt, pq;
	st_t   rate_sat;
	logic signed [34:0] inner;
	logic signed [33:0] s_w;
	logic               s_pos;
	logic               accept;
	logic               out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign pdt = wide_t'(mul_prod >>> DT_BITS);
	assign pq  = wide_t'(mul_prod >>> FRAC_BITS);

	assign rate_sat = sat32(wide_t'(rin_q) - wide_t'(bias_q));
	assign inner = 35'(d11_q) - 35'(pab_q) - 35'(pba_q) + $signed({19'd0, angle_noise_q});
	assign s_w   = 34'(paa_q) + $signed({10'd0, measure_noise_q});
	assign s_pos = !s_w[33] && (s_w != '0);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_ANG: begin
				mul_a = MUL_W'(rate_sat);
				mul_b = $signed({20'd0, dt_q});
			end
			OP_D11: begin
				mul_a = MUL_W'(pbb_q);
				mul_b = $signed({20'd0, dt_q});
			end
			OP_INN: begin
				mul_a = MUL_W'(inner);
				mul_b = $signed({20'd0, dt_q});
			end
			OP_BN: begin
				mul_a = $signed({20'd0, bias_noise_q});
				mul_b = $signed({20'd0, dt_q});
			end
			OP_KA: begin
				mul_a = MUL_W'(k0_q);
				mul_b = MUL_W'(y_q);
			end
			OP_KB: begin
				mul_a = MUL_W'(k1_q);
				mul_b = MUL_W'(y_q);
			end
			OP_PBA: begin
				mul_a = MUL_W'(k1_q);
				mul_b = MUL_W'(paa_q);
			end
			OP_PAA: begin
				mul_a = MUL_W'(k0_q);
				mul_b = MUL_W'(paa_q);
			end
			OP_PBB: begin
				mul_a = MUL_W'(k1_q);
				mul_b = MUL_W'(pab_q);
			end
			OP_PAB: begin
				mul_a = MUL_W'(k0_q);
				mul_b = MUL_W'(pab_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_num = (op_q == OP_K1) ? pba_q : paa_q;

	kab_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart_q),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	kab_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart_q),
		.num    (div_num),
		.den    (s_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			op_q            <= OP_ANG;
			mstart_q        <= 1'b0;
			dstart_q        <= 1'b0;
			out_valid_q     <= 1'b0;
			angle_noise_q   <= ANGLE_NOISE_RST;
			bias_noise_q    <= BIAS_NOISE_RST;
			measure_noise_q <= MEASURE_NOISE_RST;
			ang_q           <= '0;
			bias_q          <= '0;
			paa_q           <= ONE_Q;
			pab_q           <= '0;
			pba_q           <= '0;
			pbb_q           <= ONE_Q;
			d11_q           <= '0;
			k0_q            <= '0;
			k1_q            <= '0;
			y_q             <= '0;
			s_q             <= '0;
		end else begin
			mstart_q <= 1'b0;
			dstart_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					REG_ANGLE_NOISE:   angle_noise_q   <= cfg_data[NOISE_W-1:0];
					REG_BIAS_NOISE:    bias_noise_q    <= cfg_data[NOISE_W-1:0];
					REG_MEASURE_NOISE: measure_noise_q <= cfg_data[MEAS_N_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= OP_ANG;
						mstart_q <= 1'b1;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						mstart_q <= 1'b1;
						case (op_q)
							OP_ANG: begin
								ang_q <= sat32(wide_t'(ang_q) + pdt);
								op_q  <= OP_D11;
							end
							OP_D11: begin
								d11_q <= sat32(pdt);
								op_q  <= OP_INN;
							end
							OP_INN: begin
								paa_q <= sat32(wide_t'(paa_q) + pdt);
								pab_q <= sat32(wide_t'(pab_q) - wide_t'(d11_q));
								pba_q <= sat32(wide_t'(pba_q) - wide_t'(d11_q));
								op_q  <= OP_BN;
							end
							OP_BN: begin
								pbb_q    <= sat32(wide_t'(pbb_q) + pdt);
								mstart_q <= 1'b0;
								// correction only for a positive innovation variance
								if (s_pos) begin
									y_q      <= sat32(wide_t'(meas_q) - wide_t'(ang_q));
									s_q      <= s_w[DEN_W-1:0];
									op_q     <= OP_K0;
									dstart_q <= 1'b1;
									state_q  <= S_DIV;
								end else begin
									state_q <= S_OUT;
								end
							end
							OP_KA: begin
								ang_q <= sat32(wide_t'(ang_q) + pq);
								op_q  <= OP_KB;
							end
							OP_KB: begin
								bias_q <= sat32(wide_t'(bias_q) + pq);
								op_q   <= OP_PBA;
							end
							// bias rows first: they need the old angle row
							OP_PBA: begin
								pba_q <= sat32(wide_t'(pba_q) - pq);
								op_q  <= OP_PAA;
							end
							OP_PAA: begin
								paa_q <= sat32(wide_t'(paa_q) - pq);
								op_q  <= OP_PBB;
							end
							OP_PBB: begin
								pbb_q <= sat32(wide_t'(pbb_q) - pq);
								op_q  <= OP_PAB;
							end
							OP_PAB: begin
								pab_q    <= sat32(wide_t'(pab_q) - pq);
								mstart_q <= 1'b0;
								state_q  <= S_OUT;
							end
							default: begin
								mstart_q <= 1'b0;
								state_q  <= S_OUT;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (op_q == OP_K0) begin
							k0_q     <= div_quo;
							op_q     <= OP_K1;
							dstart_q <= 1'b1;
						end else begin
							k1_q     <= div_quo;
							op_q     <= OP_KA;
							mstart_q <= 1'b1;
							state_q  <= S_MUL;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q <= measured_angle;
			rin_q  <= measured_rate;
			dt_q   <= time_step;
		end
		if (state_q == S_OUT && out_free) begin
			if (ang_q > st_t'(ANGLE_LIMIT))
				out_q <= ANGLE_LIMIT;
			else if (ang_q < -st_t'(ANGLE_LIMIT))
				out_q <= -ANGLE_LIMIT;
			else
				out_q <= ang_q[IN_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_angle = out_q;

endmodule

// ===== hw/rtl/kab_checker.sv =====
// Port-level checker for the tilt filter, bound to the top level.
`timescale 1ns / 1ps
`include "kalman_angle_bias_filter_assert.svh"
module kab_port_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [kab_pkg::IN_W-1:0] filtered_angle
);
	import kab_pkg::*;

	logic angle_in_range;

	assign angle_in_range = (filtered_angle <= ANGLE_LIMIT) && (filtered_angle >= -ANGLE_LIMIT);

	`KAB_ASSERT_HOLD(a_out_hold, clk, arst_n, out_valid && !out_ready, filtered_angle)
	`KAB_ASSERT(a_out_range, clk, arst_n, out_valid |-> angle_in_range)
	`KAB_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`KAB_ASSERT(a_no_early_result, clk, arst_n, in_valid && in_ready && !out_valid |=> !out_valid)

endmodule

bind kalman_angle_bias_filter kab_port_checker u_kab_checker (.*);

// ===== test/kab_checker.sv =====
// Checker for the tilt filter: watches both channels, predicts each angle and compares.
`timescale 1ns / 1ps
module kab_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [kab_pkg::IN_W-1:0]   measured_angle,
	input  logic signed [kab_pkg::IN_W-1:0]   measured_rate,
	input  logic [kab_pkg::DT_W-1:0]          time_step,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [kab_pkg::IN_W-1:0]   filtered_angle,
	input  logic                              cfg_we,
	input  logic [kab_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kab_pkg::CFG_W-1:0]         cfg_data,
	output int                                errors,
	output int                                pending
);
	import kab_pkg::*;

	typedef logic signed [63:0] w64_t;

	logic [15:0] angle_noise, bias_noise;
	logic [23:0] measure_noise;
	w64_t ang, bias, paa, pab, pba, pbb;
	logic signed [IN_W-1:0] angle_q[$];

	function automatic w64_t clamp32(input w64_t v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// >>> on a signed 64-bit value is a floor shift
	function automatic w64_t scale_dt(input w64_t x, input logic [15:0] dt);
		w64_t p;
		p = x * w64_t'({48'd0, dt});
		return p >>> DT_BITS;
	endfunction

	function automatic w64_t qmul(input w64_t a, input w64_t b);
		w64_t p;
		p = a * b;
		return p >>> FRAC_BITS;
	endfunction

	task automatic filter_step(input logic signed [IN_W-1:0] meas_in,
			input logic signed [IN_W-1:0] rate_in, input logic [15:0] dt);
		w64_t meas, rate, d11, inner, s, y, k0, k1, ta, tb, res;
		meas = meas_in;
		rate = clamp32(w64_t'(rate_in) - bias);
		ang = clamp32(ang + scale_dt(rate, dt));
		d11 = scale_dt(pbb, dt);
		inner = d11 - pab - pba + w64_t'({48'd0, angle_noise});
		paa = clamp32(paa + scale_dt(inner, dt));
		pab = clamp32(pab - d11);
		pba = clamp32(pba - d11);
		pbb = clamp32(pbb + scale_dt(w64_t'({48'd0, bias_noise}), dt));
		s = paa + w64_t'({40'd0, measure_noise});
		if (s > 0) begin
			y = clamp32(meas - ang);
			k0 = clamp32((paa <<< FRAC_BITS) / s);
			k1 = clamp32((pba <<< FRAC_BITS) / s);
			ang = clamp32(ang + qmul(k0, y));
			bias = clamp32(bias + qmul(k1, y));
			ta = paa;
			tb = pab;
			paa = clamp32(paa - qmul(k0, ta));
			pab = clamp32(pab - qmul(k0, tb));
			pba = clamp32(pba - qmul(k1, ta));
			pbb = clamp32(pbb - qmul(k1, tb));
		end
		res = ang;
		if (res > 64'sd11796480) res = 64'sd11796480;
		if (res < -64'sd11796480) res = -64'sd11796480;
		angle_q.push_back(res[IN_W-1:0]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_noise <= ANGLE_NOISE_RST;
			bias_noise <= BIAS_NOISE_RST;
			measure_noise <= MEASURE_NOISE_RST;
			ang = 0; bias = 0; paa = 65536; pab = 0; pba = 0; pbb = 65536;
			angle_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ANGLE_NOISE: angle_noise <= cfg_data[15:0];
					REG_BIAS_NOISE: bias_noise <= cfg_data[15:0];
					REG_MEASURE_NOISE: measure_noise <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (angle_q.size() == 0) begin
					$display("%0t: unexpected beat, actual %0d", $time, filtered_angle);
					errors <= errors + 1;
				end else begin
					if (filtered_angle !== angle_q[0]) begin
						$display("%0t: filtered_angle mismatch, expected %0d actual %0d",
							$time, angle_q[0], filtered_angle);
						errors <= errors + 1;
					end
					void'(angle_q.pop_front());
				end
			end
			if (in_valid && in_ready)
				filter_step(measured_angle, measured_rate, time_step);
			pending <= angle_q.size();
		end
	end
endmodule

// ===== test/tb_kalman_angle_bias_filter.sv =====
// Testbench top for the tilt filter: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module tb_kalman_angle_bias_filter;
	import kab_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic signed [IN_W-1:0] measured_angle = 0, measured_rate = 0, filtered_angle;
	logic [DT_W-1:0] time_step = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [CFG_W-1:0] cfg_data = 0;
	int errors, pending;
	int idle_pct = 38;
	int hold_off = 0;
	logic hold_req = 0;

	always #2 clk = ~clk;

	kalman_angle_bias_filter dut (.*);

	kab_checker chk (.*);

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_req) begin
			hold_off <= 2000;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// valid stays up after the accepting edge; the next beat or drain takes it down
	task automatic send_beat(input logic signed [IN_W-1:0] a, input logic signed [IN_W-1:0] r,
			input logic [DT_W-1:0] dt);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		measured_angle <= a;
		measured_rate <= r;
		time_step <= dt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic signed [IN_W-1:0] rnd_field(input int lim);
		case ($urandom_range(9))
			0: return IN_W'($urandom);
			1: return IN_W'(lim);
			2: return IN_W'(-lim);
			default: return IN_W'($signed($urandom_range(2 * lim)) - lim);
		endcase
	endfunction

	task automatic random_beats(input int n);
		logic [DT_W-1:0] dt;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(7))
				0: dt = DT_W'($urandom);
				1: dt = 16'hffff;
				2: dt = '0;
				default: dt = DT_W'($urandom_range(200));
			endcase
			send_beat(rnd_field(11796480), rnd_field(16384000), dt);
		end
	endtask

	initial begin
		#200000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: field extremes, zero dt, full dt, out-of-range patterns
		send_beat(25'sd0, 25'sd0, 16'd0);
		send_beat(25'sd11796480, 25'sd16384000, 16'hffff);
		send_beat(-25'sd11796480, -25'sd16384000, 16'hffff);
		send_beat(25'h0ffffff, 25'h1000000, 16'd66);
		send_beat(25'h1000000, 25'h0ffffff, 16'hffff);
		send_beat(25'h1555555, 25'h0aaaaaa, 16'h5555);
		send_beat(25'h0aaaaaa, 25'h1555555, 16'haaaa);
		send_beat(25'sd12345, -25'sd678, 16'd1);
		drain();
		// zero measurement noise: correction may be skipped
		write_reg(REG_ANGLE_NOISE, 24'd0);
		write_reg(REG_BIAS_NOISE, 24'd0);
		write_reg(REG_MEASURE_NOISE, 24'd0);
		write_reg(REG_UNUSED, 24'hffffff);
		send_beat(25'sd1000, 25'sd2000, 16'hffff);
		send_beat(-25'sd5000, 25'sd300, 16'd0);
		send_beat(25'sd11796480, 25'sd0, 16'hffff);
		drain();
		// upper extremes, heavy covariance growth
		write_reg(REG_ANGLE_NOISE, 24'hffff);
		write_reg(REG_BIAS_NOISE, 24'hffff);
		write_reg(REG_MEASURE_NOISE, 24'hffffff);
		random_beats(60);
		// long receiver hold-off while sender keeps offering
		in_valid <= 1'b0;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		random_beats(10);
		drain();
		write_reg(REG_ANGLE_NOISE, 24'd66);
		write_reg(REG_BIAS_NOISE, 24'd197);
		write_reg(REG_MEASURE_NOISE, 24'd1);
		random_beats(80);
		drain();
		write_reg(REG_ANGLE_NOISE, CFG_W'($urandom));
		write_reg(REG_BIAS_NOISE, CFG_W'($urandom));
		write_reg(REG_MEASURE_NOISE, 24'd81920);
		random_beats(100);
		// stretch without idling
		idle_pct = 0;
		random_beats(60);
		idle_pct = 38;
		drain();
		write_reg(REG_MEASURE_NOISE, CFG_W'($urandom_range(24'hffffff, 1)));
		random_beats(90);
		drain();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
